// File: design/asdp_pkg.sv
// Package for the ASCII signed decimal parser: transaction payload types,
// character codes and status codes.
// Depends on nothing; used by asdp_core and ascii_signed_decimal_parser_unit.
package asdp_pkg;

    // Character codes and radix
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam int unsigned RADIX     = 10;

    // Result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Input transaction
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       no_data;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic signed [31:0] number;
        logic               status;
    } t_out_item;

    // Parse state flags, visible to the top level
    typedef struct packed {
        logic started;
        logic negative;
    } t_parse_flags;

endpackage

// File: design/ascii_signed_decimal_parser_unit.sv
// ASCII signed decimal parser, top level: input register, parse step and
// result register. Depends on asdp_pkg and asdp_core.

// Takes one received byte per transaction and builds signed 32-bit two's
// complement numbers from ASCII decimal text. Before a number starts, '-'
// starts a negative number and other non-digits are skipped; digits
// accumulate as value*10 + digit, wrapping mod 2^32. The first non-digit
// after the start gives a result with status 0; a '-' after the start, or a
// transaction with no_data set, gives status 1 and number 0. Every result
// clears the parse state. A byte passes the input register and then the result
// register, and one byte is taken every cycle: the multiply-by-ten is a
// single shift-and-add between the two registers, and the input side stalls
// only while the result register is held by a stall.
module ascii_signed_decimal_parser_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  asdp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output asdp_pkg::t_out_item o_out_data
);

    logic                   r_in_valid;
    asdp_pkg::t_in_item     r_in_data;
    logic                   r_out_valid;
    asdp_pkg::t_out_item    r_out_data;

    logic                   out_free;
    logic                   advance;
    logic                   emit;
    asdp_pkg::t_out_item    result;
    asdp_pkg::t_parse_flags flags;

    // Handshake control
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_data <= i_in_data;
        end
    end

    // Parse step
    asdp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_data),
        .o_emit   (emit),
        .o_result (result),
        .o_flags  (flags)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    // An error result always carries a zero number
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == asdp_pkg::STATUS_ERR) |-> o_out_data.number == '0)
        else $error("error result with non-zero number");

    // A negative sign is only held inside a started number
    a_neg_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flags.negative |-> flags.started)
        else $error("negative flag set without a started number");

    // Producing a result clears the parse state
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && emit) |=> (!flags.started && !flags.negative))
        else $error("parse state not cleared after a result");
`endif

endmodule

// File: design/asdp_core.sv
// Parse state and single-byte update step of the decimal parser.
// Depends on asdp_pkg.
module asdp_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  asdp_pkg::t_in_item   i_item,
    output logic                 o_emit,
    output asdp_pkg::t_out_item  o_result,
    output asdp_pkg::t_parse_flags o_flags
);

    logic [31:0] r_acc, n_acc;
    logic        r_negative, n_negative;
    logic        r_started, n_started;

    logic        is_digit;
    logic        is_minus;
    logic [7:0]  digit_wide;
    logic [3:0]  digit;
    logic [31:0] acc_x10;
    logic [31:0] acc_value;

    // Character classification
    always_comb begin
        is_digit   = (i_item.rx_byte inside {[asdp_pkg::CHAR_ZERO:asdp_pkg::CHAR_NINE]});
        is_minus   = (i_item.rx_byte == asdp_pkg::CHAR_MINUS);
        digit_wide = i_item.rx_byte - asdp_pkg::CHAR_ZERO;
        digit      = digit_wide[3:0];
    end

    // acc * 10 + digit as shift-and-add, wrapping mod 2^32
    assign acc_x10 = {r_acc[28:0], 3'b000} + {r_acc[30:0], 1'b0} + {28'd0, digit};

    // Signed value of a finished number, negation wraps
    assign acc_value = r_negative ? (32'd0 - r_acc) : r_acc;

    // Next state and result for one byte
    always_comb begin
        n_acc             = r_acc;
        n_negative        = r_negative;
        n_started         = r_started;
        o_emit            = 1'b0;
        o_result.number   = '0;
        o_result.status   = asdp_pkg::STATUS_OK;
        if (i_item.no_data) begin
            o_emit          = 1'b1;
            o_result.status = asdp_pkg::STATUS_ERR;
        end else if (is_minus) begin
            if (r_started) begin
                o_emit          = 1'b1;
                o_result.status = asdp_pkg::STATUS_ERR;
            end else begin
                n_negative = 1'b1;
                n_started  = 1'b1;
            end
        end else if (is_digit) begin
            n_started = 1'b1;
            n_acc     = acc_x10;
        end else if (r_started) begin
            o_emit          = 1'b1;
            o_result.number = acc_value;
        end
        // any result returns the state to its reset values
        if (o_emit) begin
            n_acc      = '0;
            n_negative = 1'b0;
            n_started  = 1'b0;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_negative <= 1'b0;
            r_started  <= 1'b0;
        end else if (i_step) begin
            r_acc      <= n_acc;
            r_negative <= n_negative;
            r_started  <= n_started;
        end
    end

    assign o_flags.started  = r_started;
    assign o_flags.negative = r_negative;

endmodule
